// ===== rtl/acc_pkg.sv =====
// shared types, codes and microcode program of the accumulator machine
package acc_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned PC_W   = 10;
  localparam int unsigned BASE_W = 10;
  localparam int unsigned STEP_W = 5;

  // item op codes
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_EXEC  = 2'd2;

  // instruction opcodes
  localparam logic [WORD_W-1:0] OPC_HALT   = 32'd0;
  localparam logic [WORD_W-1:0] OPC_CONST  = 32'd1;
  localparam logic [WORD_W-1:0] OPC_LOAD   = 32'd2;
  localparam logic [WORD_W-1:0] OPC_ADD    = 32'd3;
  localparam logic [WORD_W-1:0] OPC_MUL    = 32'd4;
  localparam logic [WORD_W-1:0] OPC_STORE  = 32'd5;
  localparam logic [WORD_W-1:0] OPC_BRANCH = 32'd6;
  localparam logic [WORD_W-1:0] OPC_PRINT  = 32'd7;
  localparam logic [WORD_W-1:0] OPC_SLEEP  = 32'd8;
  localparam logic [WORD_W-1:0] OPC_SHELL  = 32'd9;

  typedef enum logic [2:0] {
    KIND_WRDONE = 3'd0,
    KIND_READ   = 3'd1,
    KIND_EXEC   = 3'd2,
    KIND_PRINT  = 3'd3,
    KIND_SLEEP  = 3'd4,
    KIND_SHELL  = 3'd5,
    KIND_HALTED = 3'd6
  } kind_e;

  typedef struct packed {
    logic [1:0]               op;
    logic [BASE_W-1:0]        address;
    logic signed [WORD_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic [2:0]               kind;
    logic signed [WORD_W-1:0] value;
    logic [PC_W-1:0]          pc_out;
  } res_t;

  typedef enum logic [2:0] {
    ASEL_ITEM, ASEL_PC, ASEL_PC1, ASEL_OPND_RD, ASEL_OPND
  } asel_e;

  typedef enum logic {WSEL_ITEM, WSEL_ACC} wsel_e;

  typedef enum logic [1:0] {PC_HOLD, PC_INC2, PC_BRANCH} pc_op_e;

  typedef enum logic [2:0] {
    ACC_HOLD, ACC_OPND, ACC_LOAD, ACC_ADD, ACC_MUL
  } acc_op_e;

  typedef enum logic [1:0] {VSEL_ZERO, VSEL_RDATA, VSEL_ACC, VSEL_OPND} vsel_e;

  typedef enum logic [1:0] {SEQ_NEXT, SEQ_END, SEQ_JHALT, SEQ_DISPATCH} seq_e;

  // one microcode word
  typedef struct packed {
    asel_e               asel;
    logic                mem_en;
    logic                mem_we;
    wsel_e               wsel;
    logic                ld_opcode;
    logic                ld_operand;
    pc_op_e              pc_op;
    acc_op_e             acc_op;
    logic                set_halt;
    logic                emit;
    kind_e               kind;
    vsel_e               vsel;
    seq_e                seq;
    logic [STEP_W-1:0]   target;
  } cw_t;

  // datapath status seen by the sequencer
  typedef struct packed {
    logic              halted;
    logic [WORD_W-1:0] opcode;
  } dp_stat_t;

  // program steps
  localparam logic [STEP_W-1:0] S_IGN      = 5'd0;
  localparam logic [STEP_W-1:0] S_WR       = 5'd1;
  localparam logic [STEP_W-1:0] S_RD0      = 5'd2;
  localparam logic [STEP_W-1:0] S_RD1      = 5'd3;
  localparam logic [STEP_W-1:0] S_EX0      = 5'd4;
  localparam logic [STEP_W-1:0] S_EX1      = 5'd5;
  localparam logic [STEP_W-1:0] S_EX2      = 5'd6;
  localparam logic [STEP_W-1:0] S_HLT      = 5'd7;
  localparam logic [STEP_W-1:0] X_CONST    = 5'd8;
  localparam logic [STEP_W-1:0] X_LOAD     = 5'd9;
  localparam logic [STEP_W-1:0] X_ADD      = 5'd10;
  localparam logic [STEP_W-1:0] X_MUL      = 5'd11;
  localparam logic [STEP_W-1:0] X_STORE    = 5'd12;
  localparam logic [STEP_W-1:0] X_BRANCH   = 5'd13;
  localparam logic [STEP_W-1:0] X_PRINT    = 5'd14;
  localparam logic [STEP_W-1:0] X_SLEEP    = 5'd15;
  localparam logic [STEP_W-1:0] X_SHELL    = 5'd16;
  localparam logic [STEP_W-1:0] X_NOP      = 5'd17;
  localparam logic [STEP_W-1:0] S_LAST     = X_NOP;

  localparam cw_t CW_NOP = '{
    asel:       ASEL_ITEM,
    mem_en:     1'b0,
    mem_we:     1'b0,
    wsel:       WSEL_ITEM,
    ld_opcode:  1'b0,
    ld_operand: 1'b0,
    pc_op:      PC_HOLD,
    acc_op:     ACC_HOLD,
    set_halt:   1'b0,
    emit:       1'b0,
    kind:       KIND_EXEC,
    vsel:       VSEL_ZERO,
    seq:        SEQ_END,
    target:     S_IGN
  };

  function automatic logic [STEP_W-1:0] entry_step(logic [1:0] op);
    logic [STEP_W-1:0] s;
    case (op)
      OP_WRITE: s = S_WR;
      OP_READ:  s = S_RD0;
      OP_EXEC:  s = S_EX0;
      default:  s = S_IGN;
    endcase
    return s;
  endfunction

  function automatic logic [STEP_W-1:0] dispatch_step(logic [WORD_W-1:0] opcode);
    logic [STEP_W-1:0] s;
    case (opcode)
      OPC_HALT:   s = S_HLT;
      OPC_CONST:  s = X_CONST;
      OPC_LOAD:   s = X_LOAD;
      OPC_ADD:    s = X_ADD;
      OPC_MUL:    s = X_MUL;
      OPC_STORE:  s = X_STORE;
      OPC_BRANCH: s = X_BRANCH;
      OPC_PRINT:  s = X_PRINT;
      OPC_SLEEP:  s = X_SLEEP;
      OPC_SHELL:  s = X_SHELL;
      default:    s = X_NOP;
    endcase
    return s;
  endfunction

  function automatic cw_t ucode(logic [STEP_W-1:0] step);
    cw_t cw;
    cw = CW_NOP;
    case (step)
      S_IGN: begin
        cw.seq = SEQ_END;
      end
      S_WR: begin
        cw.asel   = ASEL_ITEM;
        cw.mem_en = 1'b1;
        cw.mem_we = 1'b1;
        cw.wsel   = WSEL_ITEM;
        cw.emit   = 1'b1;
        cw.kind   = KIND_WRDONE;
        cw.vsel   = VSEL_ZERO;
      end
      S_RD0: begin
        cw.asel   = ASEL_ITEM;
        cw.mem_en = 1'b1;
        cw.seq    = SEQ_NEXT;
      end
      S_RD1: begin
        cw.emit = 1'b1;
        cw.kind = KIND_READ;
        cw.vsel = VSEL_RDATA;
      end
      S_EX0: begin
        cw.asel   = ASEL_PC;
        cw.mem_en = 1'b1;
        cw.seq    = SEQ_JHALT;
        cw.target = S_HLT;
      end
      S_EX1: begin
        cw.ld_opcode = 1'b1;
        cw.asel      = ASEL_PC1;
        cw.mem_en    = 1'b1;
        cw.seq       = SEQ_NEXT;
      end
      S_EX2: begin
        cw.ld_operand = 1'b1;
        cw.pc_op      = PC_INC2;
        cw.asel       = ASEL_OPND_RD;
        cw.mem_en     = 1'b1;
        cw.seq        = SEQ_DISPATCH;
      end
      S_HLT: begin
        cw.set_halt = 1'b1;
        cw.emit     = 1'b1;
        cw.kind     = KIND_HALTED;
        cw.vsel     = VSEL_ZERO;
      end
      X_CONST: begin
        cw.acc_op = ACC_OPND;
        cw.emit   = 1'b1;
        cw.vsel   = VSEL_ACC;
      end
      X_LOAD: begin
        cw.acc_op = ACC_LOAD;
        cw.emit   = 1'b1;
        cw.vsel   = VSEL_ACC;
      end
      X_ADD: begin
        cw.acc_op = ACC_ADD;
        cw.emit   = 1'b1;
        cw.vsel   = VSEL_ACC;
      end
      X_MUL: begin
        cw.acc_op = ACC_MUL;
        cw.emit   = 1'b1;
        cw.vsel   = VSEL_ACC;
      end
      X_STORE: begin
        cw.asel   = ASEL_OPND;
        cw.mem_en = 1'b1;
        cw.mem_we = 1'b1;
        cw.wsel   = WSEL_ACC;
        cw.emit   = 1'b1;
        cw.vsel   = VSEL_ACC;
      end
      X_BRANCH: begin
        cw.pc_op = PC_BRANCH;
        cw.emit  = 1'b1;
        cw.vsel  = VSEL_ACC;
      end
      X_PRINT: begin
        cw.emit = 1'b1;
        cw.kind = KIND_PRINT;
        cw.vsel = VSEL_ACC;
      end
      X_SLEEP: begin
        cw.emit = 1'b1;
        cw.kind = KIND_SLEEP;
        cw.vsel = VSEL_OPND;
      end
      X_SHELL: begin
        cw.emit = 1'b1;
        cw.kind = KIND_SHELL;
        cw.vsel = VSEL_OPND;
      end
      X_NOP: begin
        cw.emit = 1'b1;
        cw.vsel = VSEL_ACC;
      end
      default: begin
        cw = CW_NOP;
      end
    endcase
    return cw;
  endfunction

endpackage

// ===== rtl/acc_ram.sv =====
// generic single-port ram with registered read
module acc_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // read data holds until the next read
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/acc_useq.sv =====
// microcode sequencer: step counter, control store and jumps
module acc_useq (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  logic [1:0]       op_i,
  input  acc_pkg::dp_stat_t stat_i,
  output acc_pkg::cw_t     cw_o,
  output logic             busy_o
);
  import acc_pkg::*;

  logic              run_q, run_d;
  logic [STEP_W-1:0] step_q, step_d;
  cw_t               cw;

  assign cw = ucode(step_q);

  always_comb begin
    run_d  = run_q;
    step_d = step_q;
    if (!run_q) begin
      if (accept_i) begin
        run_d  = 1'b1;
        step_d = entry_step(op_i);
      end
    end else begin
      case (cw.seq)
        SEQ_NEXT:     step_d = step_q + 1'b1;
        SEQ_JHALT:    step_d = stat_i.halted ? cw.target : step_q + 1'b1;
        SEQ_DISPATCH: step_d = dispatch_step(stat_i.opcode);
        SEQ_END:      run_d  = 1'b0;
        default:      run_d  = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      step_q <= S_IGN;
    end else begin
      run_q  <= run_d;
      step_q <= step_d;
    end
  end

  assign cw_o   = run_q ? cw : CW_NOP;
  assign busy_o = run_q;

  a_accept_runs: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && !run_q) |=> run_q)
    else $error("sequencer did not start after an accepted transaction");

  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    run_q |-> (step_q <= S_LAST))
    else $error("step counter left the program");

  a_fetch_path: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (run_q && step_q == S_EX0) |=> (run_q && (step_q == S_EX1 || step_q == S_HLT)))
    else $error("bad step after first fetch");

endmodule

// ===== rtl/acc_dp.sv =====
// datapath: word memory, accumulator, program counter and result register
module acc_dp #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                accept_i,
  input  acc_pkg::item_t      item_i,
  input  logic                cfg_we_i,
  input  logic [acc_pkg::BASE_W-1:0] cfg_data_i,
  input  acc_pkg::cw_t        cw_i,
  output acc_pkg::dp_stat_t   stat_o,
  output logic                res_strobe_o,
  output acc_pkg::res_t       res_o
);
  import acc_pkg::*;

  localparam int unsigned AW = $clog2(MEM_WORDS);

  item_t             item_q;
  logic [BASE_W-1:0] base_q;
  logic [WORD_W-1:0] acc_q, acc_d;
  logic [PC_W-1:0]   pc_q, pc_d;
  logic              halted_q, halted_d;
  logic [WORD_W-1:0] opcode_q, operand_q;
  logic              res_strobe_q;
  res_t              res_q;

  logic [WORD_W-1:0] rdata;
  logic [WORD_W-1:0] base_w, sum_pc, addr_w, wdata, value;
  logic [AW-1:0]     mem_addr;
  logic              acc_pos;

  // address sums wrap at 32 bits, then the low bits pick the word
  assign base_w = WORD_W'(base_q);
  assign sum_pc = base_w + WORD_W'(pc_q);

  always_comb begin
    case (cw_i.asel)
      ASEL_ITEM:    addr_w = WORD_W'(item_q.address);
      ASEL_PC:      addr_w = sum_pc;
      ASEL_PC1:     addr_w = sum_pc + 32'd1;
      ASEL_OPND_RD: addr_w = base_w + rdata;
      ASEL_OPND:    addr_w = base_w + operand_q;
      default:      addr_w = WORD_W'(item_q.address);
    endcase
  end

  assign mem_addr = addr_w[AW-1:0];
  assign wdata    = (cw_i.wsel == WSEL_ACC) ? acc_q : item_q.data;

  acc_ram #(
    .WIDTH(WORD_W),
    .DEPTH(MEM_WORDS)
  ) u_ram (
    .clk_i   (clk_i),
    .en_i    (cw_i.mem_en),
    .we_i    (cw_i.mem_we),
    .addr_i  (mem_addr),
    .wdata_i (wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    case (cw_i.acc_op)
      ACC_OPND: acc_d = operand_q;
      ACC_LOAD: acc_d = rdata;
      ACC_ADD:  acc_d = acc_q + rdata;
      ACC_MUL:  acc_d = acc_q * rdata;
      default:  acc_d = acc_q;
    endcase
  end

  // positive means nonzero with the sign bit clear
  assign acc_pos = (acc_q != '0) && !acc_q[WORD_W-1];

  always_comb begin
    case (cw_i.pc_op)
      PC_INC2:   pc_d = pc_q + PC_W'(2);
      PC_BRANCH: pc_d = acc_pos ? rdata[PC_W-1:0] : pc_q;
      default:   pc_d = pc_q;
    endcase
  end

  assign halted_d = halted_q | cw_i.set_halt;

  always_comb begin
    case (cw_i.vsel)
      VSEL_RDATA: value = rdata;
      VSEL_ACC:   value = acc_d;
      VSEL_OPND:  value = operand_q;
      default:    value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q       <= '0;
      acc_q        <= '0;
      pc_q         <= '0;
      halted_q     <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        base_q <= cfg_data_i;
      end
      acc_q        <= acc_d;
      pc_q         <= pc_d;
      halted_q     <= halted_d;
      res_strobe_q <= cw_i.emit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      item_q <= item_i;
    end
    if (cw_i.ld_opcode) begin
      opcode_q <= rdata;
    end
    if (cw_i.ld_operand) begin
      operand_q <= rdata;
    end
    if (cw_i.emit) begin
      res_q.kind   <= cw_i.kind;
      res_q.value  <= value;
      res_q.pc_out <= pc_d;
    end
  end

  assign stat_o.halted = halted_q;
  assign stat_o.opcode = opcode_q;
  assign res_strobe_o  = res_strobe_q;
  assign res_o         = res_q;

  a_strobe_from_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_q |-> $past(cw_i.emit))
    else $error("result strobe without an emitting step");

  a_halt_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    halted_q |=> halted_q)
    else $error("halted flag cleared");

  a_halted_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_strobe_q && res_q.kind == KIND_HALTED) |-> (res_q.value == '0))
    else $error("halted result with nonzero value");

endmodule

// ===== rtl/accumulator_cpu_step.sv =====
// top level of the microcoded accumulator machine
// a write runs step S_WR, a read S_RD0 and S_RD1, an execute S_EX0, S_EX1, S_EX2 and
// the step its opcode selects, or S_EX0 and S_HLT when already halted, and an ignored
// op S_IGN; the result strobe comes in the cycle after the last step, from the result
// register; busy drops in that cycle, and a new transaction can be taken from then;
// reset clears pc, accumulator, halted flag and base; the word memory is not cleared;
// results cannot be stalled by the receiver, base is written only while idle
module accumulator_cpu_step #(
  parameter int unsigned MEM_WORDS = 1024
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  acc_pkg::item_t             item_i,
  output logic                       res_strobe_o,
  output acc_pkg::res_t              res_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [acc_pkg::BASE_W-1:0] cfg_data_i
);
  import acc_pkg::*;

  logic     accept;
  logic     seq_busy;
  cw_t      cw;
  dp_stat_t stat;

  assign accept      = start && !seq_busy;
  assign busy        = seq_busy;
  // base only changes between transactions
  assign cfg_ready_o = !seq_busy && !start;

  acc_useq u_useq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (item_i.op),
    .stat_i   (stat),
    .cw_o     (cw),
    .busy_o   (seq_busy)
  );

  acc_dp #(
    .MEM_WORDS(MEM_WORDS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .item_i       (item_i),
    .cfg_we_i     (cfg_valid_i && cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .cw_i         (cw),
    .stat_o       (stat),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

endmodule

// ===== test/acc_sb_pkg.sv =====
// scoreboard class: predicts the accumulator machine's results and checks them in order
package acc_sb_pkg;
  import acc_pkg::*;

  localparam int unsigned MEM_WORDS   = 1024;

  class acc_scoreboard;
    logic [WORD_W-1:0] mem [MEM_WORDS];
    bit                written [MEM_WORDS];
    logic [PC_W-1:0]   pc;
    logic [WORD_W-1:0] acc;
    bit                halted;
    logic [BASE_W-1:0] base;
    res_t              result_q[$];
    int unsigned       fails;

    function new();
      foreach (mem[i]) begin
        mem[i]     = '0;
        written[i] = 1'b0;
      end
      pc     = '0;
      acc    = '0;
      halted = 1'b0;
      base   = '0;
      fails  = 0;
    endfunction

    function void set_base(logic [BASE_W-1:0] b);
      base = b;
    endfunction

    function int unsigned pending();
      return result_q.size();
    endfunction

    function void add_result(kind_e k, logic [WORD_W-1:0] v);
      res_t r;
      r.kind   = k;
      r.value  = v;
      r.pc_out = pc;
      result_q.push_back(r);
    endfunction

    // one accepted transaction: update the machine state and queue its result, if it has one
    function void note_item(item_t it);
      logic [BASE_W-1:0] p0;
      logic [BASE_W-1:0] p1;
      logic [BASE_W-1:0] a;
      logic [WORD_W-1:0] opc;
      logic [WORD_W-1:0] opnd;
      case (it.op)
        OP_WRITE: begin
          mem[it.address]     = it.data;
          written[it.address] = 1'b1;
          add_result(KIND_WRDONE, '0);
        end
        OP_READ: begin
          add_result(KIND_READ, mem[it.address]);
        end
        OP_EXEC: begin
          if (halted) begin
            add_result(KIND_HALTED, '0);
          end else begin
            p0   = base + pc;
            p1   = p0 + 1'b1;
            opc  = mem[p0];
            opnd = mem[p1];
            pc   = pc + 2'd2;
            // operand address wraps in 32 bits, then modulo memory size
            a    = base + opnd[BASE_W-1:0];
            case (opc)
              OPC_HALT: begin
                halted = 1'b1;
                add_result(KIND_HALTED, '0);
              end
              OPC_PRINT: add_result(KIND_PRINT, acc);
              OPC_SLEEP: add_result(KIND_SLEEP, opnd);
              OPC_SHELL: add_result(KIND_SHELL, opnd);
              default: begin
                case (opc)
                  OPC_CONST: acc = opnd;
                  OPC_LOAD:  acc = mem[a];
                  OPC_ADD:   acc = acc + mem[a];
                  OPC_MUL:   acc = acc * mem[a];
                  OPC_STORE: begin
                    mem[a]     = acc;
                    written[a] = 1'b1;
                  end
                  OPC_BRANCH: begin
                    if (acc != '0 && !acc[WORD_W-1]) pc = mem[a][PC_W-1:0];
                  end
                  default: ;
                endcase
                add_result(KIND_EXEC, acc);
              end
            endcase
          end
        end
        default: ; // unused op code causes nothing
      endcase
    endfunction

    function void report(string field, logic [WORD_W-1:0] exp_v, logic [WORD_W-1:0] act_v);
      fails++;
      $display("%0t: %s expected %h actual %h", $time, field, exp_v, act_v);
    endfunction

    function void check_result(res_t got);
      res_t e;
      if (result_q.size() == 0) begin
        fails++;
        $display("%0t: result expected none actual kind %0d value %h pc %0d",
                 $time, got.kind, got.value, got.pc_out);
        return;
      end
      e = result_q.pop_front();
      if (got.kind !== e.kind) report("kind", e.kind, got.kind);
      if (got.value !== e.value) report("value", e.value, got.value);
      if (got.pc_out !== e.pc_out) report("pc_out", e.pc_out, got.pc_out);
    endfunction
  endclass

endpackage

// ===== test/accumulator_cpu_step_tb.sv =====
// testbench of accumulator_cpu_step: directed items, random programs, base changes, halt at end
module accumulator_cpu_step_tb;
  import acc_pkg::*;
  import acc_sb_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int unsigned RANDOM_ITEMS = 1350;
  localparam int unsigned PHASES       = 8;
  localparam int unsigned DATA_OFS     = 512;
  localparam int unsigned SETTLE       = 8;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  item_t             item_i;
  logic              res_strobe_o;
  res_t              res_o;
  logic              cfg_valid_i;
  logic              cfg_ready_o;
  logic [BASE_W-1:0] cfg_data_i;

  acc_scoreboard sb = new();
  int unsigned   item_count = 0;
  bit            no_idle = 1'b0;

  accumulator_cpu_step #(
    .MEM_WORDS(MEM_WORDS)
  ) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .item_i      (item_i),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) sb.check_result(res_o);
  end

  initial begin
    #10_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [WORD_W-1:0] random_word();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return 32'd1;
      2: return '1;
      3: return 32'h7FFF_FFFF;
      4: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [WORD_W-1:0] random_opcode();
    if ($urandom_range(0, 15) != 0) return $urandom_range(OPC_CONST, OPC_SHELL);
    case ($urandom_range(0, 2))
      0: return OPC_SHELL + 1'b1;
      1: return '1;
      default: return $urandom | 32'h10;
    endcase
  endfunction

  function automatic logic [BASE_W-1:0] random_addr();
    return BASE_W'($urandom_range(0, 1023));
  endfunction

  // memory operands mostly point into a small data window above base
  function automatic logic [WORD_W-1:0] random_operand(logic [WORD_W-1:0] opc);
    logic [WORD_W-1:0] w;
    if (!(opc inside {OPC_LOAD, OPC_ADD, OPC_MUL, OPC_STORE, OPC_BRANCH})) return random_word();
    w = $urandom;
    case ($urandom_range(0, 7))
      0: return w;
      1: begin
        w[BASE_W-1:0] = BASE_W'(DATA_OFS + $urandom_range(0, 15));
        return w;
      end
      default: return DATA_OFS + $urandom_range(0, 15);
    endcase
  endfunction

  task automatic push_item(logic [1:0] op, logic [BASE_W-1:0] addr, logic [WORD_W-1:0] data);
    item_t       it;
    int unsigned gap;
    it.op      = op;
    it.address = addr;
    it.data    = data;
    gap        = pick_gap();
    @(negedge clk_i);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy);
    sb.note_item(it);
    if (op != OP_UNUSED) item_count++;
  endtask

  task automatic write_word(logic [BASE_W-1:0] addr, logic [WORD_W-1:0] data);
    push_item(OP_WRITE, addr, data);
  endtask

  task automatic read_word(logic [BASE_W-1:0] addr);
    if (!sb.written[addr]) write_word(addr, random_word());
    push_item(OP_READ, addr, $urandom);
  endtask

  // make sure the next fetch and its operand access only touch written words
  task automatic prepare_exec(bit halt_ok);
    logic [BASE_W-1:0] p0;
    logic [BASE_W-1:0] p1;
    logic [BASE_W-1:0] a;
    if (sb.halted) return;
    p0 = sb.base + sb.pc;
    p1 = p0 + 1'b1;
    if (!sb.written[p0] || (!halt_ok && sb.mem[p0] == OPC_HALT))
      write_word(p0, random_opcode());
    if (!sb.written[p1]) write_word(p1, random_operand(sb.mem[p0]));
    a = sb.base + sb.mem[p1][BASE_W-1:0];
    if (!sb.written[a]) write_word(a, random_word());
  endtask

  task automatic exec_step(bit halt_ok);
    prepare_exec(halt_ok);
    push_item(OP_EXEC, random_addr(), $urandom);
  endtask

  task automatic noise_item();
    case ($urandom_range(0, 3))
      0: write_word(random_addr(), random_word());
      1: read_word(random_addr());
      2: push_item(OP_UNUSED, random_addr(), $urandom);
      default: exec_step(1'b0);
    endcase
  endtask

  // lay down a short program at the current pc, then run it
  task automatic run_program();
    int unsigned       n;
    logic [BASE_W-1:0] prog_addr;
    logic [WORD_W-1:0] opc;
    n         = $urandom_range(2, 8);
    prog_addr = sb.base + sb.pc;
    repeat (n) begin
      opc = random_opcode();
      write_word(prog_addr, opc);
      write_word(prog_addr + 1'b1, random_operand(opc));
      prog_addr = prog_addr + 2'd2;
    end
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) noise_item();
      exec_step(1'b0);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_base(logic [BASE_W-1:0] b);
    repeat ($urandom_range(0, 3)) @(negedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_base(b);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned       ph;
    int unsigned       phase_target;
    logic [BASE_W-1:0] b;
    logic [BASE_W-1:0] halt_at;
    rst_ni      = 1'b0;
    start       = 1'b0;
    item_i      = '0;
    cfg_valid_i = 1'b0;
    cfg_data_i  = '0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: extremes, every item op, wrapped operand, unknown opcode, pc and fetch wrap
    write_word(10'd1023, 32'h7FFF_FFFF);
    read_word(10'd1023);
    write_word(10'd0, OPC_CONST);
    write_word(10'd1, 32'h8000_0000);
    exec_step(1'b0);
    read_word(10'd0);
    write_word(10'd2, 32'hFFFF_FFFF);
    write_word(10'd3, 32'd1023);
    exec_step(1'b0);
    push_item(OP_UNUSED, '1, '1);
    write_word(10'd4, OPC_MUL);
    write_word(10'd5, 32'hFFFF_FFFF);
    exec_step(1'b0);
    write_word(10'd6, OPC_CONST);
    write_word(10'd7, 32'd5);
    exec_step(1'b0);
    write_word(10'd8, OPC_BRANCH);
    write_word(10'd9, 32'd10);
    write_word(10'd10, 32'd1023);
    exec_step(1'b0);
    // fetch at 1023 wraps the operand to word 0 and pc to 1
    exec_step(1'b0);

    for (ph = 0; ph < PHASES; ph++) begin
      if (ph != 0) begin
        wait_idle();
        case (ph)
          1, 7:    b = '1;
          3:       b = '0;
          5:       b = 10'd1;
          default: b = BASE_W'($urandom_range(2, 1022));
        endcase
        write_base(b);
      end
      no_idle      = (ph % 3 == 1);
      phase_target = item_count + RANDOM_ITEMS / PHASES;
      while (item_count < phase_target) begin
        if ($urandom_range(0, 3) != 0) run_program();
        else noise_item();
      end
    end

    // halt, then execute while halted; writes and reads keep working
    no_idle = 1'b0;
    halt_at = sb.base + sb.pc;
    write_word(halt_at, OPC_HALT);
    exec_step(1'b1);
    repeat (3) exec_step(1'b1);
    repeat (20) noise_item();

    wait_idle();
    if (sb.fails == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== accumulator_cpu_step.f =====
rtl/acc_pkg.sv
rtl/acc_ram.sv
rtl/acc_useq.sv
rtl/acc_dp.sv
rtl/accumulator_cpu_step.sv
test/acc_sb_pkg.sv
test/accumulator_cpu_step_tb.sv
